/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define FDD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define FDD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/core/fdd_pkg.sv */
package fdd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SLOPE_W = 48;
  // |dy| << (FRAC_BITS+1) plus |dx|, the rounded dividend
  localparam int QW = FRAC_BITS + 35;
  localparam int DW = 34;
  localparam int EXT_W = QW + SLOPE_W;
  localparam int CW = $clog2(QW + 1);

  localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
  localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_PEND,
    ST_CUR,
    ST_LAST,
    ST_COMMIT
  } state_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_PEND,
    EMIT_CUR,
    EMIT_LAST
  } emit_sel_t;

  typedef struct packed {
    logic      load_in;
    logic      div_start;
    logic      div_step;
    logic      div_store;
    emit_sel_t emit;
    logic      commit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] seen;
    logic       have;
    logic       pend_valid;
    logic       last;
    logic       div_done;
    logic       out_free;
  } status_t;

endpackage

/* rtl/core/forward_difference_derivative.sv */
// One request at a time. A sample with nonzero spacing runs through the restoring divider;
// a zero-spacing sample skips it, and the first sample of a set goes from check to commit.
// The second sample of a set only parks its result and emits nothing.
// Results leave through a registered output; a stalled output holds the emit states.
// Synchronous reset clears the controller, the set tracking and the output valid flag.
module forward_difference_derivative
  import fdd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [31:0]        sample_x,
  input  logic signed [31:0]        sample_y,
  input  logic                      end_of_set,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        point_x,
  output logic signed [SLOPE_W-1:0] slope,
  output logic                      last_point
);

  `include "assert_macros.svh"

  cmd_t    cmd;
  status_t status;

  fdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  fdd_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .sample_x   (sample_x),
    .sample_y   (sample_y),
    .end_of_set (end_of_set),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .point_x    (point_x),
    .slope      (slope),
    .last_point (last_point)
  );

  // busy right after taking a request
  `FDD_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  // never overwrite a result still waiting downstream
  `FDD_ASSERT_IMP(a_emit_slot_free, clk, rst, cmd.emit != EMIT_NONE, status.out_free)
  // slope is stored only once the divider has finished
  `FDD_ASSERT_IMP(a_store_after_div, clk, rst, cmd.div_store, status.div_done)
  // a new emit always yields a valid result next cycle
  `FDD_ASSERT_NXT(a_emit_valid, clk, rst, cmd.emit != EMIT_NONE, out_valid)

endmodule

/* rtl/core/fdd_ctrl.sv */
module fdd_ctrl
  import fdd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output cmd_t    cmd,
  output logic    in_stall
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.emit = EMIT_NONE;
    in_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.seen == 2'd0) begin
          state_next = ST_COMMIT;
        end else if (status.have) begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_PEND;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          state_next = ST_PEND;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_PEND: begin
        // second sample of a set only parks its result
        if (status.seen == 2'd1) begin
          state_next = ST_COMMIT;
        end else if (!status.pend_valid) begin
          state_next = ST_CUR;
        end else if (status.out_free) begin
          cmd.emit = EMIT_PEND;
          state_next = ST_CUR;
        end
      end
      ST_CUR: begin
        if (!status.have) begin
          state_next = ST_LAST;
        end else if (status.out_free) begin
          cmd.emit = EMIT_CUR;
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        if (!status.last) begin
          state_next = ST_COMMIT;
        end else if (status.out_free) begin
          cmd.emit = EMIT_LAST;
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/fdd_datapath.sv */
module fdd_datapath
  import fdd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic signed [31:0]        sample_x,
  input  logic signed [31:0]        sample_y,
  input  logic                      end_of_set,
  input  cmd_t                      cmd,
  output status_t                   status,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        point_x,
  output logic signed [SLOPE_W-1:0] slope,
  output logic                      last_point
);

  logic signed [31:0] prev_x, prev_y, cur_x, cur_y;
  logic               cur_last;
  logic signed [32:0] dx, dy;
  logic [1:0]         seen;
  logic               pend_valid;
  logic signed [31:0] pend_x;
  logic [SLOPE_W-1:0] pend_slope, recent_slope, pair_slope;

  logic               neg;
  logic [QW-1:0]      dvd;
  logic [DW-1:0]      rem;
  logic [DW-1:0]      d2;
  logic [CW-1:0]      cnt;

  logic [32:0]        mag_x, mag_y;
  logic [QW-1:0]      dividend;
  logic [DW:0]        trial;
  logic               qbit;
  logic [EXT_W-1:0]   q_ext;
  logic [SLOPE_W-1:0] sat;
  logic               out_free;

  assign mag_x = dx[32] ? $unsigned(-dx) : $unsigned(dx);
  assign mag_y = dy[32] ? $unsigned(-dy) : $unsigned(dy);
  // 2*(|dy| << F) + |dx| over 2*|dx| gives round half away from zero
  assign dividend = (QW'(mag_y) << (FRAC_BITS + 1)) + QW'(mag_x);

  assign trial = {rem, dvd[QW-1]};
  assign qbit  = (trial >= {1'b0, d2});

  assign q_ext = EXT_W'(dvd);
  always_comb begin
    if (neg) begin
      if (q_ext >= EXT_W'(SLOPE_MIN)) begin
        sat = SLOPE_MIN;
      end else begin
        sat = -q_ext[SLOPE_W-1:0];
      end
    end else begin
      if (q_ext > EXT_W'(SLOPE_MAX)) begin
        sat = SLOPE_MAX;
      end else begin
        sat = q_ext[SLOPE_W-1:0];
      end
    end
  end

  assign out_free = !out_valid || !out_stall;

  assign status.seen       = seen;
  assign status.have       = (dx != 33'sd0);
  assign status.pend_valid = pend_valid;
  assign status.last       = cur_last;
  assign status.div_done   = (cnt == '0);
  assign status.out_free   = out_free;

  // request capture and differences
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_x    <= sample_x;
      cur_y    <= sample_y;
      cur_last <= end_of_set;
      dx       <= {sample_x[31], sample_x} - {prev_x[31], prev_x};
      dy       <= {sample_y[31], sample_y} - {prev_y[31], prev_y};
    end
  end

  // restoring divider, quotient shifts into dvd
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_start) begin
      cnt <= CW'(QW);
    end else if (cmd.div_step) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg <= dx[32] ^ dy[32];
      dvd <= dividend;
      rem <= '0;
      d2  <= {mag_x, 1'b0};
    end else if (cmd.div_step) begin
      rem <= qbit ? DW'(trial - {1'b0, d2}) : trial[DW-1:0];
      dvd <= {dvd[QW-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pair_slope <= '0;
    end else if (cmd.div_store) begin
      pair_slope <= sat;
    end
  end

  // set tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x       <= '0;
      prev_y       <= '0;
      seen         <= 2'd0;
      pend_valid   <= 1'b0;
      recent_slope <= '0;
    end else begin
      if (cmd.div_store) begin
        recent_slope <= sat;
      end
      if (cmd.commit) begin
        prev_x <= cur_x;
        prev_y <= cur_y;
        if (cur_last) begin
          seen         <= 2'd0;
          pend_valid   <= 1'b0;
          recent_slope <= '0;
        end else begin
          case (seen)
            2'd0: seen <= 2'd1;
            2'd1: begin
              seen       <= 2'd2;
              pend_valid <= status.have;
            end
            default: begin
              seen       <= 2'd3;
              pend_valid <= 1'b0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && seen == 2'd1) begin
      pend_x     <= prev_x;
      pend_slope <= pair_slope;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_PEND: begin
        point_x    <= pend_x;
        slope      <= pend_slope;
        last_point <= 1'b0;
      end
      EMIT_CUR: begin
        point_x    <= prev_x;
        slope      <= pair_slope;
        last_point <= 1'b0;
      end
      EMIT_LAST: begin
        point_x    <= cur_x;
        slope      <= recent_slope;
        last_point <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule
